### rtl/core/ubdc_pkg.sv
// Package for the UART baud divider calculator.
// Holds the sequencer operation codes, the command/status structs and the divider code map.
// No dependencies.
package ubdc_pkg;

  localparam int DivW  = 48;
  localparam int DsrW  = 32;

  typedef enum logic [4:0] {
    OP_LOAD, OP_CHK0, OP_GCD, OP_NUM, OP_DEN, OP_SCALE, OP_M, OP_N,
    OP_NUMF, OP_DENF, OP_DIVR, OP_GCD2, OP_TNUM, OP_TDEN, OP_MUL,
    OP_ACH, OP_LIM, OP_MODV, OP_EMIT
  } op_t;

  typedef struct packed {
    logic start;
    logic exec;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic b_zero;
    logic in_zero;
    logic need_scale;
  } sts_t;

  localparam logic [2:0] CODE_D1 = 3'h5;
  localparam logic [2:0] CODE_D2 = 3'h4;
  localparam logic [2:0] CODE_D3 = 3'h3;
  localparam logic [2:0] CODE_D4 = 3'h2;
  localparam logic [2:0] CODE_D5 = 3'h1;
  localparam logic [2:0] CODE_D6 = 3'h0;
  localparam logic [2:0] CODE_D7 = 3'h6;

  function automatic logic [2:0] div_code(input logic [2:0] d);
    logic [2:0] c;
    c = CODE_D1;
    unique case (d)
      3'd2:    c = CODE_D2;
      3'd3:    c = CODE_D3;
      3'd4:    c = CODE_D4;
      3'd5:    c = CODE_D5;
      3'd6:    c = CODE_D6;
      3'd7:    c = CODE_D7;
      default: c = CODE_D1;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/ubdc_if.sv
// Request and response channel interfaces of the UART baud divider calculator.
// No dependencies.
interface ubdc_req_if;
  logic        valid;
  logic        ready;
  logic [27:0] baud_rate;
  modport source (output valid, output baud_rate, input ready);
  modport sink (input valid, input baud_rate, output ready);
endinterface

interface ubdc_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  ref_div_code;
  logic [15:0] increment_value;
  logic [15:0] modulator_value;
  modport source (output valid, output accepted, output ref_div_code,
                  output increment_value, output modulator_value, input ready);
  modport sink (input valid, input accepted, input ref_div_code,
                input increment_value, input modulator_value, output ready);
endinterface

### rtl/core/ubdc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ubdc_pkg.
module ubdc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ubdc_pkg::DivW-1:0]  dividend,
  input  logic [ubdc_pkg::DsrW-1:0]  divisor,
  output logic                       done,
  output logic [ubdc_pkg::DivW-1:0]  quot,
  output logic [ubdc_pkg::DsrW-1:0]  rem
);
  localparam int CntW = $clog2(ubdc_pkg::DivW + 1);

  logic [ubdc_pkg::DivW-1:0] q_r, q_nxt;
  logic [ubdc_pkg::DsrW-1:0] rem_r, rem_nxt, dsr_r;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [ubdc_pkg::DsrW:0]   trial;
  logic                      ge;

  assign trial = {rem_r, q_r[ubdc_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CntW'(ubdc_pkg::DivW);
    end else if (cnt_r != '0) begin
      q_nxt    = {q_r[ubdc_pkg::DivW-2:0], ge};
      rem_nxt  = ge ? ubdc_pkg::DsrW'(trial - {1'b0, dsr_r}) : trial[ubdc_pkg::DsrW-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;
endmodule

### rtl/core/ubdc_datapath.sv
// Datapath: source clock register, working registers, multiplier and result register.
// Depends on ubdc_pkg and ubdc_div.
module ubdc_datapath #(
  parameter int FIELD_MAX = 65535
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  logic [27:0]          in_baud,
  input  ubdc_pkg::cmd_t       cmd,
  output ubdc_pkg::sts_t       sts,
  output logic                 res_accepted,
  output logic [2:0]           res_code,
  output logic [15:0]          res_inc,
  output logic [15:0]          res_mod
);
  localparam logic [31:0] FMax  = 32'(FIELD_MAX);
  localparam logic [31:0] FMax7 = 32'(7 * FIELD_MAX);
  localparam logic [31:0] Hundred = 32'd100;

  logic [31:0] clk_hz_r, a_r, b_r, num_r, den_r, f_r, tnum_r, tden_r, modv_r;
  logic [27:0] baud_r;
  logic [2:0]  div_r;
  logic [47:0] prod_r, ach_r;
  logic [21:0] lim_r;
  logic        acc_r;
  logic [2:0]  code_r;
  logic [15:0] inc_r, mod_r;

  logic [47:0] dvd;
  logic [31:0] dsr, q32, q1;
  logic        done;
  logic [47:0] quot;
  logic [31:0] rem;
  logic [47:0] diff;
  logic [29:0] lim3;
  logic        ok;

  ubdc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.start), .dividend(dvd), .divisor(dsr),
    .done(done), .quot(quot), .rem(rem)
  );

  always_comb begin
    dvd = '0;
    dsr = 32'd1;
    case (cmd.op)
      ubdc_pkg::OP_GCD:  begin dvd = 48'(a_r);                  dsr = b_r;    end
      ubdc_pkg::OP_NUM,
      ubdc_pkg::OP_TNUM: begin dvd = 48'(clk_hz_r);             dsr = a_r;    end
      ubdc_pkg::OP_DEN:  begin dvd = 48'({baud_r, 4'b0});       dsr = a_r;    end
      ubdc_pkg::OP_M:    begin dvd = 48'(num_r - 32'd1);        dsr = FMax7;  end
      ubdc_pkg::OP_N:    begin dvd = 48'(den_r - 32'd1);        dsr = FMax;   end
      ubdc_pkg::OP_NUMF: begin dvd = 48'(num_r);                dsr = f_r;    end
      ubdc_pkg::OP_DENF: begin dvd = 48'(den_r);                dsr = f_r;    end
      ubdc_pkg::OP_DIVR: begin dvd = 48'(num_r - 32'd1);        dsr = FMax;   end
      ubdc_pkg::OP_TDEN: begin dvd = 48'({num_r[27:0], 4'b0});  dsr = a_r;    end
      ubdc_pkg::OP_ACH:  begin dvd = prod_r;                    dsr = tden_r; end
      ubdc_pkg::OP_LIM:  begin dvd = 48'(baud_r);               dsr = Hundred; end
      ubdc_pkg::OP_MODV: begin dvd = 48'(num_r);                dsr = 32'(div_r); end
      default: ;
    endcase
  end

  assign q32  = quot[31:0];
  assign q1   = q32 + 32'd1;
  assign diff = (ach_r >= 48'(baud_r)) ? ach_r - 48'(baud_r) : 48'(baud_r) - ach_r;
  assign lim3 = 30'(lim_r) * 30'd3;
  assign ok   = (diff < 48'(lim3)) && (baud_r != '0) && (clk_hz_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) clk_hz_r <= 32'd80000000;
    else if (cfg_we) clk_hz_r <= cfg_wdata;

    if (cmd.exec) begin
      case (cmd.op)
        ubdc_pkg::OP_LOAD: begin
          baud_r <= in_baud;
          a_r    <= clk_hz_r;
          b_r    <= {in_baud, 4'b0};
        end
        ubdc_pkg::OP_GCD2: begin
          a_r <= clk_hz_r;
          b_r <= {num_r[27:0], 4'b0};
        end
        ubdc_pkg::OP_MUL: prod_r <= 48'(tnum_r) * 48'(den_r[15:0]);
        ubdc_pkg::OP_EMIT: begin
          acc_r  <= ok;
          code_r <= ok ? ubdc_pkg::div_code(div_r) : 3'd0;
          inc_r  <= ok ? 16'(den_r - 32'd1) : 16'd0;
          mod_r  <= ok ? 16'(modv_r - 32'd1) : 16'd0;
        end
        default: ;
      endcase
    end

    if (done) begin
      case (cmd.op)
        ubdc_pkg::OP_GCD:  begin a_r <= b_r; b_r <= rem; end
        ubdc_pkg::OP_NUM:  num_r <= q32;
        ubdc_pkg::OP_DEN:  den_r <= q32;
        ubdc_pkg::OP_M:    f_r <= q1;
        ubdc_pkg::OP_N:    if (q1 > f_r) f_r <= q1;
        ubdc_pkg::OP_NUMF: num_r <= (q32 == '0) ? 32'd1 : q32;
        ubdc_pkg::OP_DENF: den_r <= (q32 == '0) ? 32'd1 : q32;
        ubdc_pkg::OP_DIVR: div_r <= q1[2:0];
        ubdc_pkg::OP_TNUM: tnum_r <= q32;
        ubdc_pkg::OP_TDEN: tden_r <= q32;
        ubdc_pkg::OP_ACH:  ach_r <= quot;
        ubdc_pkg::OP_LIM:  lim_r <= quot[21:0];
        ubdc_pkg::OP_MODV: modv_r <= q32;
        default: ;
      endcase
    end
  end

  assign sts.div_done   = done;
  assign sts.b_zero     = (b_r == '0);
  assign sts.in_zero    = (baud_r == '0) || (clk_hz_r == '0);
  assign sts.need_scale = (num_r > FMax7) || (den_r > FMax);

  assign res_accepted = acc_r;
  assign res_code     = code_r;
  assign res_inc      = inc_r;
  assign res_mod      = mod_r;
endmodule

### rtl/core/ubdc_ctrl.sv
// Controller: sequences the divider operations and owns the channel handshakes.
// Depends on ubdc_pkg.
module ubdc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ubdc_pkg::sts_t sts,
  output ubdc_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DISP  = 4'b0010,
    S_START = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  ubdc_pkg::op_t   op_r, op_nxt;
  logic            pass2_r, pass2_nxt;
  logic            ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pass2_nxt = pass2_r;
    ov_nxt    = ov_r && !out_ready;
    cmd.start = 1'b0;
    cmd.exec  = 1'b0;
    cmd.op    = op_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.op = ubdc_pkg::OP_LOAD;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          op_nxt    = ubdc_pkg::OP_CHK0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          ubdc_pkg::OP_CHK0: begin
            pass2_nxt = 1'b0;
            op_nxt    = sts.in_zero ? ubdc_pkg::OP_EMIT : ubdc_pkg::OP_GCD;
          end
          ubdc_pkg::OP_GCD:
            if (sts.b_zero) op_nxt = pass2_r ? ubdc_pkg::OP_TNUM : ubdc_pkg::OP_NUM;
            else state_nxt = S_START;
          ubdc_pkg::OP_SCALE:
            op_nxt = sts.need_scale ? ubdc_pkg::OP_M : ubdc_pkg::OP_DIVR;
          ubdc_pkg::OP_GCD2: begin
            cmd.exec  = 1'b1;
            pass2_nxt = 1'b1;
            op_nxt    = ubdc_pkg::OP_GCD;
          end
          ubdc_pkg::OP_MUL: begin
            cmd.exec = 1'b1;
            op_nxt   = ubdc_pkg::OP_ACH;
          end
          ubdc_pkg::OP_EMIT:
            if (!ov_r || out_ready) begin
              cmd.exec  = 1'b1;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end
          default: state_nxt = S_START;
        endcase
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_DISP;
          case (op_r)
            ubdc_pkg::OP_NUM:  op_nxt = ubdc_pkg::OP_DEN;
            ubdc_pkg::OP_DEN:  op_nxt = ubdc_pkg::OP_SCALE;
            ubdc_pkg::OP_M:    op_nxt = ubdc_pkg::OP_N;
            ubdc_pkg::OP_N:    op_nxt = ubdc_pkg::OP_NUMF;
            ubdc_pkg::OP_NUMF: op_nxt = ubdc_pkg::OP_DENF;
            ubdc_pkg::OP_DENF: op_nxt = ubdc_pkg::OP_DIVR;
            ubdc_pkg::OP_DIVR: op_nxt = ubdc_pkg::OP_GCD2;
            ubdc_pkg::OP_TNUM: op_nxt = ubdc_pkg::OP_TDEN;
            ubdc_pkg::OP_TDEN: op_nxt = ubdc_pkg::OP_MUL;
            ubdc_pkg::OP_ACH:  op_nxt = ubdc_pkg::OP_LIM;
            ubdc_pkg::OP_LIM:  op_nxt = ubdc_pkg::OP_MODV;
            ubdc_pkg::OP_MODV: op_nxt = ubdc_pkg::OP_EMIT;
            default:           op_nxt = op_r;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= ubdc_pkg::OP_LOAD;
      pass2_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pass2_r <= pass2_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
endmodule

### rtl/core/uart_baud_divider_calculator_unit.sv
// UART baud divider calculator, top level.
// Request channel: baud_rate (28 bits). Response channel: accepted, ref_div_code,
// increment_value, modulator_value. Config: cfg_we/cfg_wdata set the source clock in Hz.
// One response per request. A request is taken only while the sequencer is idle;
// the response sits in an output register, so a new request is taken while the
// previous response still waits for out_rsp.ready.
// Every arithmetic step runs through one shared restoring divider. A request
// needs a sequence of steps, longer when the values need scaling, plus one step
// per iteration of each of the two Euclid loops; zero baud or zero clock goes
// straight to the response without a divider step. The divider is the limit on
// throughput.
// Reset (rst_n, synchronous, active low) idles the sequencer, drops the response
// and sets the source clock to 80000000. A stalled receiver holds the finished
// response; the sequencer then waits before emitting the next one.
// Depends on ubdc_pkg, ubdc_if, ubdc_ctrl and ubdc_datapath.
module uart_baud_divider_calculator_unit #(
  parameter int FIELD_MAX = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  ubdc_req_if.sink           in_req,
  ubdc_rsp_if.source         out_rsp
);
  ubdc_pkg::cmd_t cmd;
  ubdc_pkg::sts_t sts;

  ubdc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_req.valid), .in_ready(in_req.ready),
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  ubdc_datapath #(.FIELD_MAX(FIELD_MAX)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_baud(in_req.baud_rate),
    .cmd(cmd), .sts(sts),
    .res_accepted(out_rsp.accepted), .res_code(out_rsp.ref_div_code),
    .res_inc(out_rsp.increment_value), .res_mod(out_rsp.modulator_value)
  );
endmodule
